// File: design/epg_pkg.sv
// ----------------------------------------------------------------------------
// epg_pkg: shared types and constants for the ellipse point generator
// Request and result payload structs and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package epg_pkg;

    localparam int IN_W    = 32;
    localparam int SWEEP_W = 19;
    localparam int FLAT_W  = 31;
    localparam int K_W     = 5;
    localparam int LEFT_W  = 20;
    localparam int FRAC_W  = 16;

    localparam logic       CMD_SETUP   = 1'b0;
    localparam logic       CMD_ADVANCE = 1'b1;

    localparam logic [FLAT_W-1:0] FLAT_RESET = 31'd32768;

    typedef struct packed {
        logic                     cmd;
        logic signed [IN_W-1:0]   center_x;
        logic signed [IN_W-1:0]   center_y;
        logic signed [IN_W-1:0]   p_x;
        logic signed [IN_W-1:0]   p_y;
        logic signed [IN_W-1:0]   q_x;
        logic signed [IN_W-1:0]   q_y;
        logic [SWEEP_W-1:0]       sweep_angle;
    } t_req;

    typedef struct packed {
        logic signed [IN_W-1:0]   point_x;
        logic signed [IN_W-1:0]   point_y;
        logic                     last_point;
    } t_rsp;

endpackage

`default_nettype wire

// File: design/ellipse_point_generator.sv
// ----------------------------------------------------------------------------
// ellipse_point_generator
// Steps along an elliptic arc given by a center and conjugate diameter ends,
// 16.16 fixed point, with a shared shift-add unit under a small sequencer.
// ----------------------------------------------------------------------------
// Setup request: 4 length estimates, 1 radius step, k + 1 exponent search
//   steps and 4 correction steps run in turn; k <= MAX_SHIFT.
// Advance request: q is updated through the shared x/y shift-add lanes on
//   acceptance, then p in S_ADV, where the point is loaded into the output register.
// The next request is taken only after S_ADV ends, and S_ADV waits while results are stalled.
// Reset (synchronous, i_rst_n low): idle, no points left, flatness 32768.
`default_nettype none

module ellipse_point_generator #(
    parameter int MAX_SHIFT  = 12,
    parameter int COORD_BITS = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [epg_pkg::FLAT_W-1:0]         i_cfg_wdata,
    input  wire                               i_req_valid,
    input  epg_pkg::t_req                     i_req,
    output logic                              o_req_stall,
    output logic                              o_rsp_valid,
    output epg_pkg::t_rsp                     o_rsp,
    input  wire                               i_rsp_stall
);

    localparam int CW   = COORD_BITS;
    localparam int AW   = $clog2(2 * MAX_SHIFT + 5);
    localparam int CMPW = (CW > epg_pkg::FLAT_W) ? CW : epg_pkg::FLAT_W;
    localparam int KW   = epg_pkg::K_W;
    localparam int LW   = epg_pkg::LEFT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LEN  = 3'd1;
    localparam logic [2:0] S_RAD  = 3'd2;
    localparam logic [2:0] S_SRCH = 3'd3;
    localparam logic [2:0] S_CORR = 3'd4;
    localparam logic [2:0] S_ADV  = 3'd5;

    localparam logic [1:0] B_Q = 2'd0;
    localparam logic [1:0] B_P = 2'd1;
    localparam logic [1:0] B_W = 2'd2;

    localparam logic [1:0] OP_P   = 2'd0;
    localparam logic [1:0] OP_Q   = 2'd1;
    localparam logic [1:0] OP_SUM = 2'd2;
    localparam logic [1:0] OP_DIF = 2'd3;

    logic [2:0]                 r_state;
    logic [1:0]                 r_cnt;
    logic [KW-1:0]              r_k;
    logic [LW-1:0]              r_left;
    logic [epg_pkg::FLAT_W-1:0] r_flat;
    logic                       r_rsp_valid;
    epg_pkg::t_rsp              r_rsp;

    logic signed [CW-1:0]       r_p   [2];
    logic signed [CW-1:0]       r_q   [2];
    logic signed [CW-1:0]       r_w   [2];
    logic signed [CW-1:0]       r_ctr [2];
    logic [epg_pkg::SWEEP_W-1:0] r_sweep;
    logic [CW-1:0]              r_r1;
    logic [CW-1:0]              r_r2;
    logic [CW-1:0]              r_e2;
    logic [CW-1:0]              r_e4;

    // shared shift-add lanes
    logic [1:0]                 sel_b;
    logic                       sel_a_p;
    logic                       op_sub;
    logic [AW-1:0]              amt;
    logic [AW-1:0]              sh;
    logic signed [CW-1:0]       ln_b   [2];
    logic signed [CW-1:0]       ln_a   [2];
    logic signed [CW-1:0]       ln_sh  [2];
    logic signed [CW-1:0]       ln_res [2];
    logic signed [CW-1:0]       pt     [2];
    logic signed [63:0]         pt64   [2];

    // vector length estimate
    logic signed [CW-1:0]       lx, ly;
    logic [CW-1:0]              ma, mb, big, sml, hb, eb, tt, ee, d_len;
    logic [CW-1:0]              rr1, rr2, rad, fsum;
    logic                       fok;

    logic                       req_acc;
    logic                       out_free;
    logic                       out_load;
    logic                       n_rsp_valid;

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    assign req_acc  = i_req_valid && !o_req_stall;
    assign out_free = !r_rsp_valid || !i_rsp_stall;
    assign out_load = (r_state == S_ADV) && out_free;
    assign sh       = AW'({r_k, 1'b0}) + AW'(3);

    always_comb begin
        sel_b   = B_Q;
        sel_a_p = 1'b0;
        op_sub  = 1'b1;
        amt     = AW'(r_k);
        case (r_state)
            S_IDLE: begin
                sel_b = B_P;
            end
            S_CORR: begin
                case (r_cnt)
                    2'd0: begin
                        sel_b = B_Q;
                        amt   = sh;
                    end
                    2'd1: begin
                        sel_b  = B_P;
                        amt    = AW'(r_k) + AW'(1);
                        op_sub = 1'b0;
                    end
                    2'd2: begin
                        sel_b = B_W;
                        amt   = sh + AW'(1);
                    end
                    default: begin
                        sel_b = B_W;
                        amt   = sh;
                    end
                endcase
            end
            S_ADV: begin
                sel_b   = B_Q;
                sel_a_p = 1'b1;
                op_sub  = 1'b0;
            end
            default: begin
                sel_b = B_Q;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            case (sel_b)
                B_P:     ln_b[i] = r_p[i];
                B_W:     ln_b[i] = r_w[i];
                default: ln_b[i] = r_q[i];
            endcase
            ln_a[i]   = sel_a_p ? r_p[i] : r_q[i];
            ln_sh[i]  = ln_b[i] >>> amt;
            ln_res[i] = op_sub ? (ln_a[i] - ln_sh[i]) : (ln_a[i] + ln_sh[i]);
            pt[i]     = r_ctr[i] + ln_res[i];
            pt64[i]   = 64'(pt[i]);
        end
    end

    always_comb begin
        case (r_cnt)
            OP_P: begin
                lx = r_p[0];
                ly = r_p[1];
            end
            OP_Q: begin
                lx = r_q[0];
                ly = r_q[1];
            end
            OP_SUM: begin
                lx = r_p[0] + r_q[0];
                ly = r_p[1] + r_q[1];
            end
            default: begin
                lx = r_p[0] - r_q[0];
                ly = r_p[1] - r_q[1];
            end
        endcase
        ma    = lx[CW-1] ? $unsigned(-lx) : $unsigned(lx);
        mb    = ly[CW-1] ? $unsigned(-ly) : $unsigned(ly);
        big   = (ma > mb) ? ma : mb;
        sml   = (ma > mb) ? mb : ma;
        hb    = sml >> 1;
        eb    = big >> 3;
        tt    = (hb >= eb) ? (hb - eb) : '0;
        ee    = sml >> 3;
        d_len = big + ((ee > tt) ? ee : tt);
        rr1   = r_r1 + (r_r1 >> 4);
        rr2   = r_r2 - (r_r2 >> 2);
        rad   = (rr1 > rr2) ? rr1 : rr2;
        fsum  = r_e2 + r_e4;
        fok   = CMPW'(r_flat) >= CMPW'(fsum);
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (out_load) begin
            n_rsp_valid = 1'b1;
        end else if (!i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_k         <= '0;
            r_left      <= '0;
            r_flat      <= epg_pkg::FLAT_RESET;
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
            if (i_cfg_we) begin
                r_flat <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        if (i_req.cmd == epg_pkg::CMD_SETUP) begin
                            r_state <= S_LEN;
                            r_cnt   <= '0;
                        end else if (r_left != '0) begin
                            r_state <= S_ADV;
                        end
                    end
                end
                S_LEN: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == OP_DIF) begin
                        r_state <= S_RAD;
                    end
                end
                S_RAD: begin
                    r_k     <= '0;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if ((r_k == KW'(MAX_SHIFT)) || fok) begin
                        r_left  <= LW'(r_sweep >> (KW'(epg_pkg::FRAC_W) - r_k));
                        r_cnt   <= '0;
                        r_state <= S_CORR;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_CORR: begin
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ADV: begin
                    if (out_free) begin
                        r_left  <= r_left - LW'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (i_req.cmd == epg_pkg::CMD_SETUP) begin
                        r_ctr[0] <= CW'(64'(i_req.center_x));
                        r_ctr[1] <= CW'(64'(i_req.center_y));
                        r_p[0]   <= CW'(64'(i_req.p_x));
                        r_p[1]   <= CW'(64'(i_req.p_y));
                        r_q[0]   <= CW'(64'(i_req.q_x));
                        r_q[1]   <= CW'(64'(i_req.q_y));
                        r_sweep  <= i_req.sweep_angle;
                    end else if (r_left != '0) begin
                        r_q[0] <= ln_res[0];
                        r_q[1] <= ln_res[1];
                    end
                end
            end
            S_LEN: begin
                case (r_cnt)
                    OP_P:    r_r1 <= d_len;
                    OP_Q:    r_r1 <= (d_len > r_r1) ? d_len : r_r1;
                    OP_SUM:  r_r2 <= d_len;
                    default: r_r2 <= (d_len > r_r2) ? d_len : r_r2;
                endcase
            end
            S_RAD: begin
                r_e2 <= rad >> 3;
                r_e4 <= rad >> 7;
            end
            S_SRCH: begin
                r_e2 <= r_e2 >> 2;
                r_e4 <= r_e4 >> 4;
            end
            S_CORR: begin
                r_q[0] <= ln_res[0];
                r_q[1] <= ln_res[1];
                if (sel_b != B_P) begin
                    r_w[0] <= ln_sh[0];
                    r_w[1] <= ln_sh[1];
                end
            end
            S_ADV: begin
                if (out_free) begin
                    r_p[0]           <= ln_res[0];
                    r_p[1]           <= ln_res[1];
                    r_rsp.point_x    <= pt64[0][31:0];
                    r_rsp.point_y    <= pt64[1][31:0];
                    r_rsp.last_point <= (r_left == LW'(1));
                end
            end
            default: begin
                r_sweep <= r_sweep;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/epg_checker.sv
// ----------------------------------------------------------------------------
// epg_checker: port-level checks for the ellipse point generator
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module epg_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_req_valid,
    input epg_pkg::t_req  i_req,
    input wire            o_req_stall,
    input wire            o_rsp_valid,
    input epg_pkg::t_rsp  o_rsp,
    input wire            i_rsp_stall
);

    logic req_acc;
    logic setup_acc;

    assign req_acc   = i_req_valid && !o_req_stall;
    assign setup_acc = req_acc && (i_req.cmd == epg_pkg::CMD_SETUP);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled result changed or dropped");

    // setup always goes busy
    a_setup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        setup_acc |=> o_req_stall)
        else $error("setup request did not start the sequencer");

    // setup makes no point
    a_setup_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        setup_acc |=> !$rose(o_rsp_valid))
        else $error("result appeared after setup request");

    // a new point only comes out of the busy advance step
    a_rsp_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(o_req_stall))
        else $error("result appeared without an advance in progress");

endmodule

bind ellipse_point_generator epg_checker u_epg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .i_req       (i_req),
    .o_req_stall (o_req_stall),
    .o_rsp_valid (o_rsp_valid),
    .o_rsp       (o_rsp),
    .i_rsp_stall (i_rsp_stall)
);

`default_nettype wire

// File: tb/tb_ellipse_point_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ellipse_point_generator: self-checking bench for the arc point generator
// Drives setup and advance requests with random gaps and output stalls,
// predicts every arc point in a scoreboard and compares it field by field.
// Flatness is swept through several values, the extremes included.
// ----------------------------------------------------------------------------

module tb_ellipse_point_generator;

    localparam int MAX_SHIFT     = 12;
    localparam int COORD_BITS    = 32;
    localparam int SETTLE_CYCLES = MAX_SHIFT + 16;
    localparam int PHASE_ITEMS   = 70;
    localparam int CYCLE_LIMIT   = 400000;

    typedef logic signed [epg_pkg::IN_W-1:0] t_coord;

    localparam t_coord MIN_COORD = 32'h8000_0000;
    localparam t_coord MAX_COORD = 32'h7FFF_FFFF;
    localparam logic [epg_pkg::SWEEP_W-1:0] SWEEP_MAX = 19'd411775;

    // tracks the arc state and the points still owed by the block
    class arc_walker;
        logic [epg_pkg::FLAT_W-1:0] flatness;
        int unsigned                shift_k;
        logic [epg_pkg::LEFT_W-1:0] points_left;
        t_coord                     ctr_x, ctr_y, px, py, qx, qy;
        epg_pkg::t_rsp              pending_points[$];
        int                         mismatches;

        function new();
            flatness    = epg_pkg::FLAT_RESET;
            shift_k     = 0;
            points_left = '0;
            ctr_x = '0; ctr_y = '0;
            px = '0; py = '0; qx = '0; qy = '0;
            mismatches  = 0;
        endfunction

        function bit [63:0] magnitude(t_coord v);
            longint s;
            s = v;
            return (s < 0) ? -s : s;
        endfunction

        function bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
            bit [63:0] s;
            s = a + b;
            return (s < a) ? {64{1'b1}} : s;
        endfunction

        // shift-add vector length estimate
        function bit [63:0] vec_len(t_coord x, t_coord y);
            bit [63:0] a, b, big_m, small_m, t;
            a = magnitude(x);
            b = magnitude(y);
            if (a > b) begin
                big_m = a; small_m = b;
            end else begin
                big_m = b; small_m = a;
            end
            t = (small_m / 2 >= big_m / 8) ? small_m / 2 - big_m / 8 : 64'd0;
            return sat_sum(big_m, (small_m / 8 > t) ? small_m / 8 : t);
        endfunction

        function bit [63:0] radius_estimate(t_coord ax, t_coord ay, t_coord bx, t_coord by);
            t_coord    sx, sy, dx, dy;
            bit [63:0] d1, d2, d3, d4, r1, r2, s1;
            sx = ax + bx;
            sy = ay + by;
            dx = ax - bx;
            dy = ay - by;
            d1 = vec_len(ax, ay);
            d2 = vec_len(bx, by);
            d3 = vec_len(sx, sy);
            d4 = vec_len(dx, dy);
            r1 = (d1 > d2) ? d1 : d2;
            r2 = (d3 > d4) ? d3 : d4;
            r2 = r2 - r2 / 4;
            s1 = sat_sum(r1, r1 / 16);
            return (s1 > r2) ? s1 : r2;
        endfunction

        function int unsigned step_exponent(bit [63:0] r);
            bit [63:0] e2, e4;
            e2 = r >> 3;
            e4 = r >> 7;
            for (int k = 0; k < MAX_SHIFT; k++) begin
                if (64'(flatness) >= sat_sum(e2, e4))
                    return k;
                e2 = e2 >> 2;
                e4 = e4 >> 4;
            end
            return MAX_SHIFT;
        endfunction

        // initial-value correction of the conjugate coordinate
        function t_coord start_q(t_coord u0, t_coord v0, int unsigned k);
            int unsigned sh;
            t_coord      w, u;
            sh = 2 * k + 3;
            w  = u0 >>> sh;
            u  = u0 - w + (v0 >>> (k + 1));
            w  = w >>> (sh + 1);
            u  = u - w;
            w  = w >>> sh;
            return u - w;
        endfunction

        function void take_request(epg_pkg::t_req r);
            epg_pkg::t_rsp p;
            if (r.cmd == epg_pkg::CMD_SETUP) begin
                shift_k     = step_exponent(radius_estimate(r.p_x, r.p_y, r.q_x, r.q_y));
                points_left = epg_pkg::LEFT_W'(r.sweep_angle >> (epg_pkg::FRAC_W - shift_k));
                ctr_x = r.center_x;
                ctr_y = r.center_y;
                px    = r.p_x;
                py    = r.p_y;
                qx    = start_q(r.q_x, r.p_x, shift_k);
                qy    = start_q(r.q_y, r.p_y, shift_k);
            end else if (points_left != 0) begin
                qx = qx - (px >>> shift_k);
                px = px + (qx >>> shift_k);
                qy = qy - (py >>> shift_k);
                py = py + (qy >>> shift_k);
                p.point_x    = ctr_x + px;
                p.point_y    = ctr_y + py;
                p.last_point = (points_left == 1);
                points_left  = points_left - 1'b1;
                pending_points.push_back(p);
            end
        endfunction

        function void check_point(epg_pkg::t_rsp got);
            epg_pkg::t_rsp want;
            if (pending_points.size() == 0) begin
                $error("unexpected point: point_x %0d point_y %0d last_point %0d",
                       got.point_x, got.point_y, got.last_point);
                mismatches++;
                return;
            end
            want = pending_points.pop_front();
            if (got.point_x !== want.point_x) begin
                $error("point_x: expected %0d, actual %0d", want.point_x, got.point_x);
                mismatches++;
            end
            if (got.point_y !== want.point_y) begin
                $error("point_y: expected %0d, actual %0d", want.point_y, got.point_y);
                mismatches++;
            end
            if (got.last_point !== want.last_point) begin
                $error("last_point: expected %0d, actual %0d",
                       want.last_point, got.last_point);
                mismatches++;
            end
        endfunction
    endclass

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [epg_pkg::FLAT_W-1:0] i_cfg_wdata = '0;
    logic                       i_req_valid = 1'b0;
    epg_pkg::t_req              i_req       = '0;
    logic                       o_req_stall;
    logic                       o_rsp_valid;
    epg_pkg::t_rsp              o_rsp;
    logic                       i_rsp_stall = 1'b0;

    arc_walker arcs = new();

    bit sender_idles   = 1'b0;
    bit receiver_idles = 1'b0;
    bit hold_off_req   = 1'b0;
    int items_sent     = 0;

    ellipse_point_generator #(
        .MAX_SHIFT  (MAX_SHIFT),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_rsp_stall (i_rsp_stall)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int v;
        v = $urandom_range(0, 99);
        if (!sender_idles || v < 55)
            return 0;
        if (v < 90)
            return $urandom_range(1, 3);
        if (v < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_coord rand_coord();
        int m;
        case ($urandom_range(0, 9))
            0: return MIN_COORD;
            1: return MAX_COORD;
            2: return '0;
            3, 4, 5: return $urandom;
            default: begin
                m = $urandom_range(0, 32'h01F4_0000);
                return $urandom_range(0, 1) ? -m : m;
            end
        endcase
    endfunction

    function automatic logic [epg_pkg::SWEEP_W-1:0] rand_sweep();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return SWEEP_MAX;
            2, 3, 4: return $urandom_range(0, 1023);
            5, 6: return $urandom_range(0, 65535);
            default: return $urandom_range(0, SWEEP_MAX);
        endcase
    endfunction

    function automatic epg_pkg::t_req random_req();
        epg_pkg::t_req r;
        r.cmd         = $urandom_range(0, 1);
        r.center_x    = rand_coord();
        r.center_y    = rand_coord();
        r.p_x         = rand_coord();
        r.p_y         = rand_coord();
        r.q_x         = rand_coord();
        r.q_y         = rand_coord();
        r.sweep_angle = rand_sweep();
        return r;
    endfunction

    function automatic epg_pkg::t_req advance_req();
        epg_pkg::t_req r;
        r     = random_req();
        r.cmd = epg_pkg::CMD_ADVANCE;
        return r;
    endfunction

    function automatic epg_pkg::t_req make_setup(t_coord cx, t_coord cy, t_coord ax,
                                                 t_coord ay, t_coord bx, t_coord by,
                                                 logic [epg_pkg::SWEEP_W-1:0] sweep);
        epg_pkg::t_req r;
        r.cmd         = epg_pkg::CMD_SETUP;
        r.center_x    = cx;
        r.center_y    = cy;
        r.p_x         = ax;
        r.p_y         = ay;
        r.q_x         = bx;
        r.q_y         = by;
        r.sweep_angle = sweep;
        return r;
    endfunction

    task automatic send_request(input epg_pkg::t_req r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        arcs.take_request(r);
    endtask

    // setup, then up to max_steps advances; a finished arc gets extra idle advances
    task automatic walk_arc(input epg_pkg::t_req setup, input int max_steps,
                            input int extra_steps);
        int steps;
        setup.cmd = epg_pkg::CMD_SETUP;
        send_request(setup);
        items_sent++;
        steps = arcs.points_left;
        if (steps > max_steps)
            steps = max_steps;
        items_sent += steps;
        if (steps == arcs.points_left)
            steps += extra_steps;
        repeat (steps) send_request(advance_req());
    endtask

    task automatic drain_and_settle();
        i_req_valid <= 1'b0;
        while (arcs.pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_flatness(input logic [epg_pkg::FLAT_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        arcs.flatness = v;
    endtask

    // output side: check accepted points, then pick the next stall state
    initial begin
        int stall_run;
        bit stall_now;
        int v;
        stall_run = 0;
        stall_now = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_rsp_valid && !i_rsp_stall)
                arcs.check_point(o_rsp);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_now    = 1'b1;
                stall_run    = 299;
            end else if (stall_run > 0) begin
                stall_run--;
            end else begin
                v = $urandom_range(0, 99);
                if (!receiver_idles || v < 55) begin
                    stall_now = 1'b0;
                    stall_run = receiver_idles ? $urandom_range(0, 14) : 0;
                end else begin
                    stall_now = 1'b1;
                    if (v < 90)
                        stall_run = $urandom_range(0, 2);
                    else if (v < 97)
                        stall_run = $urandom_range(3, 11);
                    else
                        stall_run = $urandom_range(19, 59);
                end
            end
            i_rsp_stall <= stall_now;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("ellipse_point_generator test failed");
        $finish;
    end

    initial begin
        logic [epg_pkg::FLAT_W-1:0] flat_plan[$];
        int                         target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests at reset flatness
        send_request(advance_req());
        walk_arc(make_setup(0, 0, 0, 0, 0, 0, '0), 4, 1);
        walk_arc(make_setup(MAX_COORD, MIN_COORD, MAX_COORD, MIN_COORD,
                            MIN_COORD, MAX_COORD, SWEEP_MAX), 3, 0);
        walk_arc(make_setup(0, 0, 1 << 16, 0, 0, 1 << 16, 19'd65536), 4, 1);
        walk_arc(make_setup(-(3 << 16), 7 << 16, -(5 << 16), 3 << 16,
                            2 << 16, -(7 << 16), 19'd196608), 8, 1);
        walk_arc(make_setup(MIN_COORD, MAX_COORD, 0, MIN_COORD, MIN_COORD, 0,
                            SWEEP_MAX), 3, 0);
        walk_arc(make_setup(12345, -1, 1, -1, -1, 1, 19'd4095), 3, 1);
        walk_arc(make_setup(0, 0, 40 << 16, 0, 0, 40 << 16, SWEEP_MAX), 2, 0);
        walk_arc(make_setup(5, 5, 9 << 16, 0, 0, 9 << 16, '0), 0, 1);

        // output held off while requests keep coming
        hold_off_req = 1'b1;
        walk_arc(make_setup(0, 0, 200 << 16, 0, 0, 120 << 16, SWEEP_MAX), 40, 0);

        flat_plan = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd4096, 31'd32768, 31'd1048576};
        flat_plan.push_back(epg_pkg::FLAT_W'($urandom));

        for (int phase = 0; phase <= flat_plan.size(); phase++) begin
            if (phase > 0) begin
                drain_and_settle();
                write_flatness(flat_plan[phase - 1]);
            end
            sender_idles   = (phase % 3 != 1);
            receiver_idles = (phase % 3 != 2);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(0, 99) < 8)
                    send_request(advance_req());
                else
                    walk_arc(random_req(), $urandom_range(1, 40), $urandom_range(0, 2));
            end
        end

        i_req_valid <= 1'b0;
        while (arcs.pending_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (arcs.mismatches == 0)
            $display("ellipse_point_generator test passed");
        else
            $display("ellipse_point_generator test failed");
        $finish;
    end

endmodule
